/* rtl/core/fl_ptm_pkg.sv */
// Shared types and constants of the four-level page table manager.
package fl_ptm_pkg;

    localparam logic [1:0] CMD_MAP       = 2'd0;
    localparam logic [1:0] CMD_UNMAP     = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;
    localparam logic [1:0] CMD_CREATE    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_PRES  = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    localparam logic CFG_KERNEL_ROOT = 1'b0;
    localparam logic CFG_POOL_BASE   = 1'b1;

    localparam int IDX_W = 9;
    localparam int ENTRY_W = 64;
    localparam logic [ENTRY_W-1:0] LINK_FLAGS = 64'h7;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;  // latch request fields
    localparam logic [3:0] OP_READ      = 4'd2;  // read entry at (cur, level index)
    localparam logic [3:0] OP_CHECK     = 4'd3;  // descend through the read link
    localparam logic [3:0] OP_ALLOC     = 4'd4;  // take next free table
    localparam logic [3:0] OP_ZERO      = 4'd5;  // zero one entry of new table
    localparam logic [3:0] OP_LINK      = 4'd6;  // write link into parent slot
    localparam logic [3:0] OP_LEAF      = 4'd7;  // write map leaf
    localparam logic [3:0] OP_CLEAR     = 4'd8;  // clear leaf
    localparam logic [3:0] OP_CREAD     = 4'd9;  // read kernel entry
    localparam logic [3:0] OP_CWRITE    = 4'd10; // write copied entry
    localparam logic [3:0] OP_RESULT    = 4'd11; // load result
    localparam logic [3:0] OP_WIPE      = 4'd12; // clearing pass after reset

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic       present;
        logic       outside;
        logic       exhausted;
        logic       last;      // counter at its final value
        logic       root_bad;
        logic       kroot_bad;
        logic [1:0] command;
        logic [1:0] level;
    } t_stat;

endpackage

/* rtl/core/fl_ptm_ctrl.sv */
// Controller state machine of the page table manager.
module fl_ptm_ctrl import fl_ptm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_WIPE  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_ALLOC = 4'd5;
    localparam logic [3:0] S_ZERO  = 4'd6;
    localparam logic [3:0] S_LINK  = 4'd7;
    localparam logic [3:0] S_CREAD = 4'd8;
    localparam logic [3:0] S_CWAIT = 4'd9;
    localparam logic [3:0] S_CWR   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_WIPE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_cmd.op   = OP_NONE;
        o_cmd.status = r_status;
        unique case (r_state)
            S_WIPE: begin
                o_cmd.op = OP_WIPE;
                if (i_st.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_status = ST_OK;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                if (i_st.command == CMD_CREATE) begin
                    if (i_st.kroot_bad) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_DONE;
                    end else if (i_st.exhausted) begin
                        n_status = ST_EXHAUSTED;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.op = OP_ALLOC;
                        n_state  = S_ZERO;
                    end
                end else if (i_st.root_bad) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: n_state = S_CHECK;
            S_CHECK: begin
                if (i_st.level == 2'd3) begin
                    unique case (i_st.command)
                        CMD_MAP: o_cmd.op = OP_LEAF;
                        CMD_UNMAP: o_cmd.op = OP_CLEAR;
                        CMD_TRANSLATE: if (!i_st.present) n_status = ST_NOT_PRES;
                        default: ;
                    endcase
                    n_state = S_DONE;
                end else if (i_st.present) begin
                    if (i_st.outside) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.op = OP_CHECK;
                        n_state  = S_READ;
                    end
                end else if (i_st.command != CMD_MAP) begin
                    n_status = ST_NOT_PRES;
                    n_state  = S_DONE;
                end else if (i_st.exhausted) begin
                    n_status = ST_EXHAUSTED;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_ALLOC;
                    n_state  = S_ZERO;
                end
            end
            S_ZERO: begin
                o_cmd.op = OP_ZERO;
                if (i_st.last) begin
                    n_state = (i_st.command == CMD_CREATE) ? S_CREAD : S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.op = OP_LINK;
                n_state  = S_READ;
            end
            S_CREAD: begin
                o_cmd.op = OP_CREAD;
                n_state  = S_CWAIT;
            end
            // The read data register reloads every cycle, so the kernel address is held.
            S_CWAIT: begin
                o_cmd.op = OP_CREAD;
                n_state  = S_CWR;
            end
            S_CWR: begin
                o_cmd.op = OP_CWRITE;
                n_state  = i_st.last ? S_DONE : S_CREAD;
            end
            S_DONE: begin
                o_cmd.op = OP_RESULT;
                n_state  = S_OUT;
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/fl_ptm_dp.sv */
// Datapath of the page table manager: table memory, walk registers and allocator.
module fl_ptm_dp import fl_ptm_pkg::*; #(
    parameter int NUM_TABLES        = 16,
    parameter int KERNEL_HALF_START = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [51:0] i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_root_table,
    input  logic [47:0] i_virt_addr,
    input  logic [51:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    input  logic        i_no_execute,
    input  t_cmd        i_cmd,
    output t_stat       o_st,
    output logic [1:0]  o_status,
    output logic [51:0] o_frame_addr,
    output logic [3:0]  o_new_root
);

    localparam int TW    = (NUM_TABLES > 2) ? $clog2(NUM_TABLES) : 1;
    localparam int CW    = TW + 1;
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = NUM_TABLES * 512;
    localparam logic [CW-1:0] NT = CW'(NUM_TABLES);
    localparam logic [IDX_W-1:0] KSTART = IDX_W'(KERNEL_HALF_START);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    logic [3:0]  r_kroot;
    logic [39:0] r_pbase;
    logic [1:0]  r_command;
    logic [3:0]  r_root;
    logic [47:0] r_va;
    logic [39:0] r_pa;
    logic [11:0] r_flags;
    logic        r_nx;
    logic [TW-1:0] r_cur;
    logic [TW-1:0] r_new;
    logic [1:0]  r_level;
    logic [CW-1:0] r_next_free;
    logic [AW-1:0] r_wipe;
    logic [IDX_W-1:0] r_cnt;
    logic [1:0]  r_status;
    logic [51:0] r_frame;
    logic [3:0]  r_new_root;

    logic [IDX_W-1:0] w_idx;
    logic [AW-1:0] w_addr;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [40:0] w_diff;
    logic        w_outside;
    logic [AW-1:0] w_raddr;

    always_comb begin
        unique case (r_level)
            2'd0: w_idx = r_va[47:39];
            2'd1: w_idx = r_va[38:30];
            2'd2: w_idx = r_va[29:21];
            default: w_idx = r_va[20:12];
        endcase
    end
    assign w_addr = {r_cur, w_idx};

    // Link offset from the pool base; a borrow means below the base.
    assign w_diff = {1'b0, r_rdata[51:12]} - {1'b0, r_pbase};
    assign w_outside = w_diff[40] || (w_diff[39:0] >= 40'(NUM_TABLES));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = '0;
        w_raddr = w_addr;
        case (i_cmd.op)
            OP_WIPE: begin
                w_we = 1'b1;
                w_waddr = r_wipe;
            end
            OP_ZERO: begin
                w_we = 1'b1;
                w_waddr = {r_new, r_cnt};
            end
            OP_LINK: begin
                w_we = 1'b1;
                w_wdata = {12'd0, r_pbase + 40'(r_new), 12'd0} | LINK_FLAGS;
            end
            OP_LEAF: begin
                w_we = 1'b1;
                w_wdata = {r_nx, 11'd0, r_pa, r_flags};
            end
            OP_CLEAR: w_we = 1'b1;
            OP_CREAD: w_raddr = {TW'(r_kroot), r_cnt};
            OP_CWRITE: begin
                w_we = 1'b1;
                w_waddr = {r_new, r_cnt};
                w_wdata = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kroot     <= '0;
            r_pbase     <= '0;
            r_next_free <= CW'(1);
            r_wipe      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KERNEL_ROOT) r_kroot <= i_cfg_data[3:0];
                else r_pbase <= i_cfg_data[51:12];
            end
            if (i_cmd.op == OP_WIPE) r_wipe <= r_wipe + AW'(1);
            if (i_cmd.op == OP_ALLOC) r_next_free <= r_next_free + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_command <= i_command;
                r_root    <= i_root_table;
                r_cur     <= TW'(i_root_table);
                r_va      <= i_virt_addr;
                r_pa      <= i_phys_addr[51:12];
                r_flags   <= i_page_flags;
                r_nx      <= i_no_execute;
                r_level   <= '0;
            end
            OP_CHECK: begin
                r_cur   <= w_diff[TW-1:0];
                r_level <= r_level + 2'd1;
            end
            OP_ALLOC: begin
                r_new <= r_next_free[TW-1:0];
                r_cnt <= '0;
            end
            OP_ZERO: r_cnt <= (r_cnt == '1 && r_command == CMD_CREATE) ? KSTART : r_cnt + 1'b1;
            OP_LINK: begin
                r_cur   <= r_new;
                r_level <= r_level + 2'd1;
            end
            OP_CWRITE: r_cnt <= r_cnt + 1'b1;
            OP_RESULT: begin
                r_status   <= i_cmd.status;
                r_frame    <= (i_cmd.status == ST_OK && r_command == CMD_TRANSLATE)
                              ? {r_rdata[51:12], 12'd0} : '0;
                r_new_root <= (i_cmd.status == ST_OK && r_command == CMD_CREATE)
                              ? 4'(r_new) : '0;
            end
            default: ;
        endcase
    end

    // A kernel root equal to the new table copies out of zeroed entries: all zero.
    assign o_st.present   = r_rdata[0];
    assign o_st.outside   = w_outside;
    assign o_st.exhausted = (r_next_free >= NT);
    assign o_st.last      = (i_cmd.op == OP_WIPE) ? (r_wipe == AW'(DEPTH - 1))
                                                  : (r_cnt == '1);
    assign o_st.root_bad  = ({28'd0, r_root} >= 32'(NUM_TABLES));
    assign o_st.kroot_bad = ({28'd0, r_kroot} >= 32'(NUM_TABLES));
    assign o_st.command   = r_command;
    assign o_st.level     = r_level;

    assign o_status     = r_status;
    assign o_frame_addr = r_frame;
    assign o_new_root   = r_new_root;

endmodule

/* rtl/core/four_level_page_table_manager.sv */
// Top level of the four-level page table manager.
// Each walked level passes through the read, wait and check states. Each level that map
// allocates zeroes a new table and then links it into the parent slot; create zeroes a
// new table and copies the kernel half of the kernel root table into it.
// One request at a time; reset is synchronous active-low, then a clearing pass zeroes
// the table memory while no request is accepted.
module four_level_page_table_manager import fl_ptm_pkg::*; #(
    parameter int NUM_TABLES        = 16,
    parameter int KERNEL_HALF_START = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [51:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_root_table,
    input  logic [47:0] i_virt_addr,
    input  logic [51:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    input  logic        i_no_execute,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [51:0] o_frame_addr,
    output logic [3:0]  o_new_root
);

    t_cmd  w_cmd;
    t_stat w_st;

    fl_ptm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_st(w_st), .o_cmd(w_cmd)
    );

    fl_ptm_dp #(
        .NUM_TABLES(NUM_TABLES), .KERNEL_HALF_START(KERNEL_HALF_START)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_command, .i_root_table, .i_virt_addr, .i_phys_addr,
        .i_page_flags, .i_no_execute,
        .i_cmd(w_cmd), .o_st(w_st),
        .o_status, .o_frame_addr, .o_new_root
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the four-level page table manager.
`timescale 1ns / 100ps

module testbench;
    import fl_ptm_pkg::*;

    localparam int TABLES = 16;
    localparam int KHALF = 256;
    localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] frame;
        logic [3:0]  new_root;
    } t_walk_result;

    typedef struct {
        logic [1:0]   cmd;
        logic [3:0]   root;
        logic [47:0]  va;
        logic [51:0]  pa;
        logic [11:0]  flags;
        logic         nx;
        bit           typed;
        t_walk_result want;
    } t_request_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_KERNEL_ROOT;
    logic [51:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_MAP;
    logic [3:0]  i_root_table = '0;
    logic [47:0] i_virt_addr = '0;
    logic [51:0] i_phys_addr = '0;
    logic [11:0] i_page_flags = '0;
    logic        i_no_execute = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [51:0] o_frame_addr;
    logic [3:0]  o_new_root;

    four_level_page_table_manager u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table memory and allocator.
    logic [63:0]  shadow_mem [0:TABLES*512-1];
    int           next_table;
    logic [3:0]   shadow_kroot;
    logic [51:0]  shadow_base;

    t_walk_result pending_results[$];
    t_request_row directed_rows[$];
    logic [3:0]   live_roots[$];
    logic [47:0]  mapped_vas[$];
    int           fail_count = 0;
    int           idle_cycles = 0;
    bit           calm = 1'b0;

    function automatic logic [51:0] table_base(int t);
        logic [63:0] a;
        a = ({12'd0, shadow_base} & FRAME_MASK) + (64'(t) << 12);
        return 52'(a & FRAME_MASK);
    endfunction

    function automatic bit follow_link(logic [63:0] entry, output int t);
        logic [63:0] a, b;
        a = entry & FRAME_MASK;
        b = {12'd0, shadow_base} & FRAME_MASK;
        t = 0;
        if (a < b || ((a - b) >> 12) >= TABLES)
            return 1'b0;
        t = int'((a - b) >> 12);
        return 1'b1;
    endfunction

    function automatic bit grab_table(output int t);
        t = next_table;
        if (next_table >= TABLES)
            return 1'b0;
        next_table++;
        for (int i = 0; i < 512; i++)
            shadow_mem[t*512+i] = '0;
        return 1'b1;
    endfunction

    function automatic int slot_of(int t, logic [47:0] va, int level);
        return t*512 + int'((va >> (39 - 9*level)) & 48'h1FF);
    endfunction

    // Applies one request to the shadow tables and returns the result it produces.
    function automatic t_walk_result walk_tables(t_request_row r);
        t_walk_result res;
        int cur, t, s;
        logic [63:0] e;
        res = '0;
        cur = int'(r.root);
        if (r.cmd == CMD_CREATE) begin
            if (!grab_table(t)) begin
                res.status = ST_EXHAUSTED;
            end else begin
                for (int i = KHALF; i < 512; i++)
                    shadow_mem[t*512+i] = shadow_mem[int'(shadow_kroot)*512+i];
                res.new_root = 4'(t);
            end
        end else if (r.cmd == CMD_MAP) begin
            for (int lv = 0; lv < 3 && res.status == ST_OK; lv++) begin
                s = slot_of(cur, r.va, lv);
                e = shadow_mem[s];
                if (e[0]) begin
                    if (!follow_link(e, cur))
                        res.status = ST_OUTSIDE;
                end else if (grab_table(t)) begin
                    shadow_mem[s] = {12'd0, table_base(t)} | LINK_FLAGS;
                    cur = t;
                end else begin
                    res.status = ST_EXHAUSTED;
                end
            end
            if (res.status == ST_OK)
                shadow_mem[slot_of(cur, r.va, 3)] =
                    {r.nx, 11'd0, r.pa[51:12], r.flags};
        end else begin
            for (int lv = 0; lv < 3 && res.status == ST_OK; lv++) begin
                e = shadow_mem[slot_of(cur, r.va, lv)];
                if (!e[0])
                    res.status = ST_NOT_PRES;
                else if (!follow_link(e, cur))
                    res.status = ST_OUTSIDE;
            end
            if (res.status == ST_OK) begin
                s = slot_of(cur, r.va, 3);
                if (r.cmd == CMD_UNMAP)
                    shadow_mem[s] = '0;
                else if (shadow_mem[s][0])
                    res.frame = 52'(shadow_mem[s] & FRAME_MASK);
                else
                    res.status = ST_NOT_PRES;
            end
        end
        return res;
    endfunction

    task automatic send_request(t_request_row r);
        t_walk_result predicted;
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= r.cmd;
        i_root_table <= r.root;
        i_virt_addr  <= r.va;
        i_phys_addr  <= r.pa;
        i_page_flags <= r.flags;
        i_no_execute <= r.nx;
        do @(posedge i_clk); while (o_stall);
        predicted = walk_tables(r);
        pending_results.push_back(r.typed ? r.want : predicted);
        if (r.cmd == CMD_CREATE && predicted.status == ST_OK)
            live_roots.push_back(predicted.new_root);
        if (r.cmd == CMD_MAP)
            mapped_vas.push_back(r.va);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [51:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KERNEL_ROOT)
            shadow_kroot = value[3:0];
        else
            shadow_base = value;
        @(negedge i_clk);
    endtask

    task automatic add_row(logic [1:0] cmd, logic [3:0] root, logic [47:0] va,
                           logic [51:0] pa, logic [11:0] flags, logic nx,
                           bit typed, logic [1:0] st, logic [51:0] fr);
        t_request_row r;
        r.cmd = cmd; r.root = root; r.va = va; r.pa = pa; r.flags = flags; r.nx = nx;
        r.typed = typed; r.want.status = st; r.want.frame = fr; r.want.new_root = '0;
        directed_rows.push_back(r);
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_request_row random_request();
        t_request_row r;
        int pick;
        pick = $urandom_range(0, 9);
        r.cmd = pick < 4 ? CMD_MAP : pick < 6 ? CMD_UNMAP : pick < 9 ? CMD_TRANSLATE : CMD_CREATE;
        if ($urandom_range(0, 4) == 0 || live_roots.size() == 0)
            r.root = 4'($urandom_range(0, 15));
        else
            r.root = live_roots[$urandom_range(0, live_roots.size()-1)];
        r.va = 48'({$urandom(), $urandom()});
        if (mapped_vas.size() != 0 && $urandom_range(0, 9) < 7) begin
            // Reuse an existing path; sometimes vary only the leaf index and page offset.
            r.va = mapped_vas[$urandom_range(0, mapped_vas.size()-1)];
            if ($urandom_range(0, 2) == 0)
                r.va[20:0] = 21'($urandom());
        end
        r.pa = 52'({$urandom(), $urandom()});
        r.flags = 12'($urandom());
        r.nx = 1'($urandom());
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Result side: random stall lengths, with calm stretches.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    always @(posedge i_clk) begin
        t_walk_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_frame_addr !== want.frame) begin
                    $error("frame_addr expected %h actual %h", want.frame, o_frame_addr);
                    fail_count++;
                end
                if (o_new_root !== want.new_root) begin
                    $error("new_root expected %0d actual %0d", want.new_root, o_new_root);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL four_level_page_table_manager");
            $finish;
        end
    end

    initial begin
        logic [51:0] base_values[5];
        logic [3:0]  kroot_values[5];
        for (int i = 0; i < TABLES*512; i++)
            shadow_mem[i] = '0;
        next_table = 1;
        shadow_kroot = '0;
        shadow_base = '0;
        live_roots.push_back(4'd0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_row(CMD_TRANSLATE, 4'd0, 48'd0, '0, '0, 1'b0, 1'b1, ST_NOT_PRES, '0);
        add_row(CMD_UNMAP, 4'd0, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, 1'b1, ST_NOT_PRES, '0);
        add_row(CMD_MAP, 4'd0, 48'd0, 52'hF_FFFF_FFFF_FFFF, 12'hFFF, 1'b1, 1'b1, ST_OK, '0);
        add_row(CMD_TRANSLATE, 4'd0, 48'd0, '0, '0, 1'b0, 1'b1, ST_OK,
                52'hF_FFFF_FFFF_F000);
        // A leaf is written even when its present bit is clear.
        add_row(CMD_MAP, 4'd0, 48'hFFFF_FFFF_FFFF, '0, 12'h0, 1'b0, 1'b1, ST_OK, '0);
        add_row(CMD_TRANSLATE, 4'd0, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, 1'b1,
                ST_NOT_PRES, '0);
        add_row(CMD_CREATE, 4'd0, '0, '0, '0, 1'b0, 1'b0, ST_OK, '0);
        add_row(CMD_TRANSLATE, 4'd7, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, 1'b0, ST_OK, '0);
        add_row(CMD_UNMAP, 4'd0, 48'd0, '0, '0, 1'b0, 1'b1, ST_OK, '0);
        add_row(CMD_TRANSLATE, 4'd0, 48'd0, '0, '0, 1'b0, 1'b1, ST_NOT_PRES, '0);
        add_row(CMD_MAP, 4'd15, 48'h1234_5678_9ABC, 52'h1_2345_6789_A000, 12'h105, 1'b0,
                1'b0, ST_OK, '0);
        add_row(CMD_TRANSLATE, 4'd15, 48'h1234_5678_9ABC, '0, '0, 1'b0, 1'b0, ST_OK, '0);
        for (int i = 0; i < 5; i++)
            add_row(CMD_CREATE, 4'd0, '0, '0, '0, 1'b0, 1'b0, ST_OK, '0);
        add_row(CMD_CREATE, 4'd0, '0, '0, '0, 1'b0, 1'b1, ST_EXHAUSTED, '0);
        add_row(CMD_MAP, 4'd0, 48'h8000_0000_0000, 52'hA_5000, 12'h3, 1'b0, 1'b1,
                ST_EXHAUSTED, '0);
        add_row(CMD_UNMAP, 4'd15, 48'h1234_5678_9ABC, '0, '0, 1'b0, 1'b0, ST_OK, '0);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        drain();

        base_values  = '{52'h0_0000_0010_0000, 52'hF_FFFF_FFFF_FFFF, 52'h0,
                         52'h8_0000_0000_0ABC, 52'h0};
        kroot_values = '{4'd15, 4'd7, 4'd0, 4'd3, 4'd0};
        for (int ph = 0; ph < 5; ph++) begin
            write_register(CFG_KERNEL_ROOT, {48'd0, kroot_values[ph]});
            write_register(CFG_POOL_BASE, base_values[ph]);
            calm = (ph == 2);
            for (int n = 0; n < 140; n++)
                send_request(random_request());
            drain();
        end
        calm = 1'b0;

        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS four_level_page_table_manager");
        else
            $display("FAIL four_level_page_table_manager");
        $finish;
    end

endmodule
